// ===== sv/hwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hwmc_pkg
// Shared types and constants for the way migration counter unit.
// ----------------------------------------------------------------------------
package hwmc_pkg;

    // Width of one access counter.
    localparam int CNT_W = 8;

    // Width of the set and way fields on the ports.
    localparam int SET_W  = 10;
    localparam int WAY_W  = 4;
    localparam int FAST_W = 2;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from the word address.
    localparam logic REG_THRESHOLD = 1'b0;

    // Reset value of the migration threshold.
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write one zero row of the clearing pass
        logic load;    // capture a new item and start its row read
        logic update;  // modify the row, write it back, drive the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // the clearing pass is at its last row
    } t_status;

endpackage

// ===== sv/hwmc_ram.sv =====
// ----------------------------------------------------------------------------
// hwmc_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module hwmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hwmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hwmc_ctrl
// Controller: clearing pass after reset, then one item at a time.
// ----------------------------------------------------------------------------
module hwmc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hwmc_pkg::t_status i_status,
    output hwmc_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    import hwmc_pkg::*;

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.clear  = (r_state == S_CLR);
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.update = (r_state == S_UPD);
    end

    assign o_busy = r_busy;

    // An item is only ever updated in the cycle right after it was loaded.
    a_upd_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> $past(o_cmd.load))
        else $error("update without a preceding load");

    // The clearing pass is over before the first item is taken.
    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_cmd.clear)
        else $error("item loaded during the clearing pass");

    // Busy drops only when the controller has gone back to idle.
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> (r_state == S_IDLE))
        else $error("busy low outside idle");

endmodule

// ===== sv/hwmc_dp.sv =====
// ----------------------------------------------------------------------------
// hwmc_dp
// Datapath: counter row store, increment, fast way search and result.
// ----------------------------------------------------------------------------
module hwmc_dp #(
    parameter int SET_COUNT = 1024,
    parameter int WAYS      = 16,
    parameter int FAST_WAYS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hwmc_pkg::t_cmd                 i_cmd,
    input  logic [hwmc_pkg::SET_W-1:0]     i_set_number,
    input  logic [hwmc_pkg::WAY_W-1:0]     i_way_number,
    input  logic [hwmc_pkg::CNT_W-1:0]     i_threshold,
    output hwmc_pkg::t_status              o_status,
    output logic                           o_done,
    output logic                           o_swap_request,
    output logic [hwmc_pkg::FAST_W-1:0]    o_fast_way,
    output logic [hwmc_pkg::WAY_W-1:0]     o_slow_way,
    output logic                           o_set_cleared
);

    import hwmc_pkg::*;

    localparam int AW   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WIB  = $clog2(WAYS);
    localparam int NF   = (FAST_WAYS < WAYS) ? FAST_WAYS : WAYS;
    localparam int FIB  = (NF > 1) ? $clog2(NF) : 1;
    localparam int ROWW = WAYS * CNT_W;

    typedef logic [WAYS-1:0][CNT_W-1:0] t_row;

    // Item registers.
    logic [AW-1:0]    r_set;
    logic [WAY_W-1:0] r_way;
    logic             r_hit;
    logic [AW-1:0]    r_clr_addr;

    // Result registers.
    logic             r_done;
    logic             r_swap;
    logic [FAST_W-1:0] r_fast;
    logic [WAY_W-1:0] r_slow;
    logic             r_cleared;

    // Incoming item decode.
    logic [31:0]   set32_in;
    logic [31:0]   way32_in;
    logic [AW-1:0] set_addr_in;
    logic          hit_in;

    assign set32_in    = 32'(i_set_number);
    assign way32_in    = 32'(i_way_number);
    assign set_addr_in = set32_in[AW-1:0];
    assign hit_in      = (set32_in < 32'(SET_COUNT)) && (way32_in < 32'(WAYS));

    // Row store.
    logic [ROWW-1:0] ram_rdata;
    logic [ROWW-1:0] ram_wdata;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic            ram_we;

    // Row update logic for the loaded item.
    t_row              row_old;
    t_row              row_new;
    logic [31:0]       way32;
    logic [WIB-1:0]    way_idx;
    logic [CNT_W-1:0]  cnt_old;
    logic [CNT_W-1:0]  cnt_new;
    logic              slow_hit;
    logic [CNT_W-1:0]  best;
    logic              found;
    logic [FIB-1:0]    fast_idx;
    logic [31:0]       fast32;

    assign row_old = t_row'(ram_rdata);
    assign way32   = 32'(r_way);
    assign way_idx = way32[WIB-1:0];
    assign cnt_old = row_old[way_idx];
    assign cnt_new = (cnt_old == {CNT_W{1'b1}}) ? cnt_old : cnt_old + 1'b1;
    assign slow_hit = r_hit && (way32 >= 32'(FAST_WAYS)) && (cnt_new >= i_threshold);

    // Search the fast ways for the first lowest count below the accessed one.
    always_comb begin
        best     = cnt_new;
        found    = 1'b0;
        fast_idx = '0;
        for (int i = 0; i < NF; i++) begin
            if (row_old[i] < best) begin
                best     = row_old[i];
                fast_idx = FIB'(i);
                found    = 1'b1;
            end
        end
    end

    assign fast32 = 32'(fast_idx);

    // New row contents: incremented, or all clear after a migration check.
    always_comb begin
        row_new          = row_old;
        row_new[way_idx] = cnt_new;
        if (slow_hit) begin
            row_new = '0;
        end
    end

    // Store port selection.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = ROWW'(row_new);
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.update && r_hit) begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = i_cmd.load ? set_addr_in : r_set;

    hwmc_ram #(
        .WIDTH (ROWW),
        .DEPTH (SET_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Clearing pass address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_status.clr_last) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last = (r_clr_addr == AW'(SET_COUNT - 1));

    // Capture the item on a transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= set_addr_in;
            r_way <= i_way_number;
            r_hit <= hit_in;
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_swap    <= slow_hit && found;
            r_fast    <= (slow_hit && found) ? fast32[FAST_W-1:0] : '0;
            r_slow    <= r_way;
            r_cleared <= slow_hit;
        end
    end

    assign o_done         = r_done;
    assign o_swap_request = r_swap;
    assign o_fast_way     = r_fast;
    assign o_slow_way     = r_slow;
    assign o_set_cleared  = r_cleared;

endmodule

// ===== sv/hybrid_way_migration_counter_unit.sv =====
// ----------------------------------------------------------------------------
// hybrid_way_migration_counter_unit
// Per-way saturating access counters with slow-to-fast way swap requests.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                         | Payload
//  ---------+-----------------------------------+-------------------------------
//  Item in  | start, busy                       | i_set_number, i_way_number
//  Result   | o_done (one cycle, no stall)      | o_swap_request, o_fast_way,
//           |                                   | o_slow_way, o_set_cleared
//  Config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  For each item, the transfer cycle starts the read of the set's counter
//  row, and the next cycle updates the row, writes it back and registers
//  the result onto o_done; the update waits for the registered read of
//  the row store. Busy stays high during the update.
//  After reset a clearing pass writes zero to every row with busy high;
//  configuration writes are taken during it.
//  Results cannot be held off by the receiver.
//
module hybrid_way_migration_counter_unit #(
    parameter int SET_COUNT = 1024,
    parameter int WAYS      = 16,
    parameter int FAST_WAYS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item channel
    input  logic                          start,
    output logic                          busy,
    input  logic [hwmc_pkg::SET_W-1:0]    i_set_number,
    input  logic [hwmc_pkg::WAY_W-1:0]    i_way_number,
    // Result channel
    output logic                          o_done,
    output logic                          o_swap_request,
    output logic [hwmc_pkg::FAST_W-1:0]   o_fast_way,
    output logic [hwmc_pkg::WAY_W-1:0]    o_slow_way,
    output logic                          o_set_cleared,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hwmc_pkg::PADDR_W-1:0]  paddr,
    input  logic [hwmc_pkg::PDATA_W-1:0]  pwdata,
    output logic [hwmc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import hwmc_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [CNT_W-1:0] r_threshold;
    logic             reg_sel;
    logic             cfg_wr;

    // Configuration register write and read.
    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
        end else if (cfg_wr && (reg_sel == REG_THRESHOLD)) begin
            r_threshold <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_THRESHOLD: prdata = PDATA_W'(r_threshold);
            default:       prdata = '0;
        endcase
    end

    // Controller.
    hwmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Datapath.
    hwmc_dp #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS),
        .FAST_WAYS (FAST_WAYS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_set_number   (i_set_number),
        .i_way_number   (i_way_number),
        .i_threshold    (r_threshold),
        .o_status       (status),
        .o_done         (o_done),
        .o_swap_request (o_swap_request),
        .o_fast_way     (o_fast_way),
        .o_slow_way     (o_slow_way),
        .o_set_cleared  (o_set_cleared)
    );

    // A transfer always yields a result, registered after the update of its row.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("transfer without a result");

    // A swap request always comes with a cleared set.
    a_swap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_swap_request) |-> o_set_cleared)
        else $error("swap request without set clear");

    // No fast way is named without a swap request.
    a_fast_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_swap_request) |-> (o_fast_way == '0))
        else $error("fast way set without swap request");

    // A result is only given while an item is in work.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result while idle");

endmodule

// ===== bench/tb_hybrid_way_migration_counter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hybrid_way_migration_counter_unit
// Self-checking bench for the way migration counter unit.
//
// A model of the per-way counters runs next to the block. Every access
// transfer is predicted when it is accepted, and each o_done strobe is
// compared with the oldest pending prediction. Directed accesses cover
// the corner cases, then hot-set traffic runs at several thresholds and
// sender idle rates.
// ----------------------------------------------------------------------------
module tb_hybrid_way_migration_counter_unit;
    import hwmc_pkg::*;

    localparam int SET_COUNT = 1024;
    localparam int WAYS      = 16;
    localparam int FAST_WAYS = 4;

    // Cycles without any transfer before the run is declared hung; covers
    // the clearing pass after reset with a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTS     = 100;

    // Register addresses.
    localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR  = 3'd4;

    // Expected content of one result transfer.
    typedef struct packed {
        logic             swap;
        logic [FAST_W-1:0] fast;
        logic [WAY_W-1:0]  slow;
        logic             cleared;
    } t_migr_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [SET_W-1:0]    i_set_number = '0;
    logic [WAY_W-1:0]    i_way_number = '0;
    logic                o_done;
    logic                o_swap_request;
    logic [FAST_W-1:0]   o_fast_way;
    logic [WAY_W-1:0]    o_slow_way;
    logic                o_set_cleared;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Model state: counters, threshold and pending predictions.
    logic [CNT_W-1:0] way_hits [SET_COUNT][WAYS];
    logic [CNT_W-1:0] migr_threshold;
    t_migr_result     pending_results [$];
    int               err_count = 0;
    int               quiet_cycles = 0;

    hybrid_way_migration_counter_unit #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS),
        .FAST_WAYS (FAST_WAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_set_number   (i_set_number),
        .i_way_number   (i_way_number),
        .o_done         (o_done),
        .o_swap_request (o_swap_request),
        .o_fast_way     (o_fast_way),
        .o_slow_way     (o_slow_way),
        .o_set_cleared  (o_set_cleared),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Counts the access, then decides on a migration and clears the set.
    function automatic t_migr_result predict_migration(
        input logic [SET_W-1:0] set_idx,
        input logic [WAY_W-1:0] way_idx
    );
        t_migr_result     res;
        logic [CNT_W-1:0] lowest;
        res = '0;
        res.slow = way_idx;
        if (set_idx < SET_COUNT && way_idx < WAYS) begin
            if (way_hits[set_idx][way_idx] != {CNT_W{1'b1}})
                way_hits[set_idx][way_idx] = way_hits[set_idx][way_idx] + 1'b1;
            if (way_idx >= FAST_WAYS && way_hits[set_idx][way_idx] >= migr_threshold) begin
                lowest = way_hits[set_idx][way_idx];
                // Strictly lower count wins, so ties keep the lower index.
                for (int i = 0; i < FAST_WAYS; i++) begin
                    if (way_hits[set_idx][i] < lowest) begin
                        lowest = way_hits[set_idx][i];
                        res.fast = i[FAST_W-1:0];
                        res.swap = 1'b1;
                    end
                end
                for (int i = 0; i < WAYS; i++)
                    way_hits[set_idx][i] = '0;
                res.cleared = 1'b1;
            end
        end
        return res;
    endfunction

    // Presents one access and holds it until the block takes the transfer.
    // Start stays high afterwards so back-to-back accesses need no gap.
    task automatic issue_access(input logic [SET_W-1:0] set_idx, input logic [WAY_W-1:0] way_idx);
        start        <= 1'b1;
        i_set_number <= set_idx;
        i_way_number <= way_idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_migration(set_idx, way_idx));
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic wait_drain(input int extra_cycles);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if ((addr >> 2) == REG_THRESHOLD)
            migr_threshold = data[CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reads the threshold back and compares it with the model.
    task automatic cfg_read_threshold();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== PDATA_W'(migr_threshold))
            report_mismatch("threshold readback", int'(prdata), int'(migr_threshold));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Threshold change between phases, with the block idle.
    task automatic set_threshold(input logic [CNT_W-1:0] thr);
        wait_drain(4);
        cfg_write(THRESHOLD_ADDR, PDATA_W'(thr));
        cfg_read_threshold();
    endtask

    // Reset value, a slow way reaching the default threshold, the extreme
    // set and way numbers, and a plain fast way access.
    task automatic test_default_threshold();
        cfg_read_threshold();
        repeat (3) issue_access(10'd0, 4'd15);
        issue_access(10'd1023, 4'd0);
        issue_access(10'd1023, 4'd1);
    endtask

    // Threshold of zero, no fast way strictly lower, the last fast way
    // chosen, and a write to an unknown register index.
    task automatic test_threshold_cases();
        set_threshold(8'd0);
        issue_access(10'd1023, 4'd4);
        set_threshold(8'd1);
        for (int w = 0; w < FAST_WAYS; w++)
            issue_access(10'd5, WAY_W'(w));
        issue_access(10'd5, 4'd9);
        set_threshold(8'd2);
        for (int w = 0; w < FAST_WAYS - 1; w++)
            repeat (2) issue_access(10'd512, WAY_W'(w));
        repeat (2) issue_access(10'd512, 4'd7);
        wait_drain(4);
        cfg_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
        cfg_read_threshold();
        repeat (2) issue_access(10'd600, 4'd8);
    endtask

    // Drives a fast way counter past 255 accesses so that it saturates, then
    // lets a slow way reach the top threshold.
    task automatic test_counter_saturation();
        set_threshold(8'd255);
        repeat (260) issue_access(10'd300, 4'd0);
        repeat (255) issue_access(10'd300, 4'd5);
    endtask

    // Traffic concentrated on a few hot sets so counters climb and migrate,
    // with some accesses spread over the whole array.
    task automatic test_mixed_traffic(
        input int              idle_pct,
        input logic [CNT_W-1:0] thr,
        input int              n_items,
        input bit              drain_often
    );
        logic [SET_W-1:0] hot_sets [4];
        logic [SET_W-1:0] set_idx;
        logic [WAY_W-1:0] way_idx;
        set_threshold(thr);
        foreach (hot_sets[i])
            hot_sets[i] = SET_W'($urandom_range(SET_COUNT - 1));
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(99) < 80)
                set_idx = hot_sets[$urandom_range(3)];
            else
                set_idx = SET_W'($urandom_range(SET_COUNT - 1));
            if ($urandom_range(1) == 0)
                way_idx = WAY_W'($urandom_range(FAST_WAYS - 1));
            else
                way_idx = WAY_W'($urandom_range(WAYS - 1, FAST_WAYS));
            // Sender pauses, either for a short gap or until all is drained.
            if (drain_often && n % 40 == 39) begin
                wait_drain(0);
            end else if ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge i_clk);
            end
            issue_access(set_idx, way_idx);
        end
    endtask

    // Result checker: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        t_migr_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_swap_request !== want.swap)
                    report_mismatch("swap_request", int'(o_swap_request), int'(want.swap));
                if (o_fast_way !== want.fast)
                    report_mismatch("fast_way", int'(o_fast_way), int'(want.fast));
                if (o_slow_way !== want.slow)
                    report_mismatch("slow_way", int'(o_slow_way), int'(want.slow));
                if (o_set_cleared !== want.cleared)
                    report_mismatch("set_cleared", int'(o_set_cleared), int'(want.cleared));
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        for (int s = 0; s < SET_COUNT; s++)
            for (int w = 0; w < WAYS; w++)
                way_hits[s][w] = '0;
        migr_threshold = THRESHOLD_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_threshold();
        test_threshold_cases();
        test_counter_saturation();
        test_mixed_traffic(0, 8'd3, 180, 1'b0);
        test_mixed_traffic(57, CNT_W'($urandom_range(8, 1)), 180, 1'b0);
        test_mixed_traffic(0, 8'd1, 120, 1'b1);
        test_mixed_traffic(37, CNT_W'($urandom_range(6, 2)), 180, 1'b0);
        test_mixed_traffic(57, 8'd0, 60, 1'b0);
        test_mixed_traffic(0, CNT_W'($urandom_range(255)), 60, 1'b0);

        wait_drain(8);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/hwmc_pkg.sv
sv/hwmc_ram.sv
sv/hwmc_ctrl.sv
sv/hwmc_dp.sv
sv/hybrid_way_migration_counter_unit.sv
bench/tb_hybrid_way_migration_counter_unit.sv
